FILE: rtl/core/ppfs_pkg.sv
// constants, register indexes and sequencer states shared by the frame store
`default_nettype none
package ppfs_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int WORD_BITS   = 8;
   localparam int BACKGROUND  = 0;

   localparam int STORE_DEPTH = (MAX_WIDTH * MAX_HEIGHT * 8) / WORD_BITS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WUNIT_MAX   = MAX_WIDTH / WORD_BITS;
   localparam int WUNIT_W     = $clog2(WUNIT_MAX + 1);
   localparam int PROD_W      = ADDR_W + 1;

   localparam int CFG_W       = 9;
   localparam int INDEX_W     = 2;

   localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [INDEX_W-1:0] REG_BITS_PER_PIXEL = 2'd2;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_CALC   = 6'b000100,
      S_READ   = 6'b001000,
      S_MODIFY = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/ppfs_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ppfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/core/packed_pixel_frame_store.sv
// packed-pixel greyscale frame store with read-modify-write pixel access
// sequencing: accept, then calc, read, modify and out states in range; calc then out out of range
// one word at a time: a new word is taken only once the last result has left the out state;
// the single ram port carries a read then, for writes, a write through a one-at-a-time sequencer
// reset: synchronous, then a clearing pass writes the background byte to every ram word;
// no request is taken during that pass, csr writes are
`default_nettype none
module packed_pixel_frame_store
   import ppfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_cmd,
   input  wire logic [7:0]         req_pixel_x,
   input  wire logic [7:0]         req_pixel_y,
   input  wire logic [7:0]         req_tone_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_tone_out,
   output logic                    rsp_out_of_range
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [8:0]        width_ff, width_in;
   logic [8:0]        height_ff, height_in;
   logic [3:0]        bpp_ff, bpp_in;

   logic              cmd_ff, cmd_in;
   logic [7:0]        x_ff, x_in;
   logic [7:0]        y_ff, y_in;
   logic [7:0]        tone_ff, tone_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        out_ff, out_in;
   logic              oor_ff, oor_in;

   logic [WUNIT_W:0]   wunit_raw;
   logic [WUNIT_W-1:0] wunit;
   logic [8:0]         w_eff;
   logic [8:0]         h_eff;
   logic [1:0]         bpp_lg;
   logic [3:0]         bpp_n;
   logic [7:0]         mask;
   logic [2:0]         bit_off;
   logic [2:0]         shift;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W+2:0]  prod_bits;
   logic               oor_now;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   // effective geometry
   assign wunit_raw = (WUNIT_W+1)'(width_ff[8:3]) + (WUNIT_W+1)'(|width_ff[2:0]);
   assign wunit     = (wunit_raw > (WUNIT_W+1)'(WUNIT_MAX)) ? WUNIT_W'(WUNIT_MAX)
                                                            : WUNIT_W'(wunit_raw);
   assign w_eff     = 9'(wunit) << 3;
   assign h_eff     = (height_ff > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_ff;

   always_comb begin
      if (bpp_ff >= 4'd8) begin
         bpp_lg = 2'd3;
      end else if (bpp_ff >= 4'd4) begin
         bpp_lg = 2'd2;
      end else if (bpp_ff >= 4'd2) begin
         bpp_lg = 2'd1;
      end else begin
         bpp_lg = 2'd0;
      end
   end

   assign bpp_n   = 4'd1 << bpp_lg;
   assign mask    = 8'((9'd1 << bpp_n) - 9'd1);
   assign bit_off = 3'({x_ff, 3'b000} >> (3 - bpp_lg));
   assign shift   = 3'(4'd8 - {1'b0, bit_off} - bpp_n);

   assign oor_now   = ({1'b0, x_ff} >= w_eff) || ({1'b0, y_ff} >= h_eff);
   assign prod      = PROD_W'(w_eff) * PROD_W'(y_ff) + PROD_W'(x_ff);
   assign prod_bits = (PROD_W+3)'(prod) << bpp_lg;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      cmd_in    = cmd_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      tone_in   = tone_ff;
      addr_in   = addr_ff;
      out_in    = out_ff;
      oor_in    = oor_ff;
      ram_we    = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = (ram_rdata & ~(mask << shift)) | ((tone_ff & mask) << shift);

      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    width_in  = csr_wdata;
            REG_IMAGE_HEIGHT:   height_in = csr_wdata;
            REG_BITS_PER_PIXEL: bpp_in    = csr_wdata[3:0];
            default:            ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = 8'(BACKGROUND);
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               x_in     = req_pixel_x;
               y_in     = req_pixel_y;
               tone_in  = req_tone_in;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            addr_in = ADDR_W'(prod_bits >> 3);
            oor_in  = oor_now;
            out_in  = 8'd0;
            state_in = oor_now ? S_OUT : S_READ;
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (cmd_ff == CMD_WRITE) begin
               ram_we = 1'b1;
               out_in = 8'd0;
            end else begin
               out_in = (ram_rdata >> shift) & mask;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         bpp_ff    <= 4'd8;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
      cmd_ff  <= cmd_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      tone_ff <= tone_in;
      addr_ff <= addr_in;
      out_ff  <= out_in;
      oor_ff  <= oor_in;
   end

   ppfs_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_tone_out     = out_ff;
   assign rsp_out_of_range = oor_ff;

   // pixel writes only for in-range write words
   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> (cmd_ff == CMD_WRITE && !oor_ff))
      else $error("ram written outside a legal pixel write");

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CALC))
      else $error("accepted word did not start address calculation");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_tone_out == 8'd0))
      else $error("out-of-range result carries a tone");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cmd_ff == CMD_WRITE) |-> (rsp_tone_out == 8'd0))
      else $error("write result carries a tone");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (req_stall && !rsp_valid))
      else $error("request path open during clearing pass");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for the packed-pixel frame store: shadow store, random traffic
`timescale 1ns / 1ps
module tb_top
   import ppfs_pkg::*;
();

   localparam int CYCLE_LIMIT     = 600000;
   localparam int WORDS_PER_PHASE = 64;
   localparam int PHASES          = 11;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   typedef struct packed {
      logic [7:0] tone;
      logic       out_of_range;
   } pixel_reply_type;

   class frame_store_shadow;
      bit [7:0]        store_bytes [STORE_DEPTH];
      bit [CFG_W-1:0]  width_reg;
      bit [CFG_W-1:0]  height_reg;
      bit [3:0]        bpp_reg;
      pixel_reply_type expected_replies [$];
      int              mismatches;

      function new();
         width_reg  = CFG_W'(MAX_WIDTH);
         height_reg = CFG_W'(MAX_HEIGHT);
         bpp_reg    = 4'd8;
         mismatches = 0;
         foreach (store_bytes[i]) store_bytes[i] = 8'(BACKGROUND);
      endfunction

      function void write_register(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH:    width_reg  = value;
            REG_IMAGE_HEIGHT:   height_reg = value;
            REG_BITS_PER_PIXEL: bpp_reg    = value[3:0];
            default: ;
         endcase
      endfunction

      function int unsigned span_x();
         int unsigned w;
         w = ((int'(width_reg) + WORD_BITS - 1) / WORD_BITS) * WORD_BITS;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned span_y();
         int unsigned h;
         h = height_reg;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         return h;
      endfunction

      function int unsigned pixel_bits();
         if (bpp_reg >= 4'd8) return 8;
         if (bpp_reg >= 4'd4) return 4;
         if (bpp_reg >= 4'd2) return 2;
         return 1;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_access(logic cmd, logic [7:0] x, logic [7:0] y, logic [7:0] tone);
         int unsigned     w, h, b, addr, shift;
         bit [7:0]        mask, word;
         pixel_reply_type reply;
         w     = span_x();
         h     = span_y();
         b     = pixel_bits();
         mask  = 8'((1 << b) - 1);
         reply = '0;
         if (x >= w || y >= h) begin
            reply.out_of_range = 1'b1;
         end else begin
            addr  = ((w * y + x) * b) / WORD_BITS;
            shift = WORD_BITS - ((x * b) % WORD_BITS) - b;
            if (addr < STORE_DEPTH) begin
               word = store_bytes[addr];
               if (cmd == CMD_WRITE) begin
                  word = (word & ~(mask << shift)) | ((tone & mask) << shift);
                  store_bytes[addr] = word;
               end else begin
                  reply.tone = (word >> shift) & mask;
               end
            end
         end
         expected_replies.push_back(reply);
      endfunction

      function void check_response(logic [7:0] tone, logic oor);
         pixel_reply_type want;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: word tone=%0d oor=%0b with nothing outstanding",
                        $time, tone, oor);
            return;
         end
         want = expected_replies.pop_front();
         if (tone !== want.tone || oor !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: expected tone=%0d oor=%0b, got tone=%0d oor=%0b",
                        $time, want.tone, want.out_of_range, tone, oor);
         end
      endfunction
   endclass

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_write        = 1'b0;
   logic [INDEX_W-1:0] csr_index        = REG_IMAGE_WIDTH;
   logic [CFG_W-1:0]   csr_wdata        = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_cmd          = CMD_READ;
   logic [7:0]         req_pixel_x      = '0;
   logic [7:0]         req_pixel_y      = '0;
   logic [7:0]         req_tone_in      = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [7:0]         rsp_tone_out;
   logic               rsp_out_of_range;

   frame_store_shadow  shadow;
   stall_style_type    stall_style      = STALL_NONE;
   int                 stall_hold       = 0;
   int                 cycle_count      = 0;
   int                 burst_left       = 0;
   bit                 valid_up         = 1'b0;
   logic [7:0]         touched_x [$];
   logic [7:0]         touched_y [$];

   int phase_table [PHASES][3] = '{
      '{8, 1, 1}, '{13, 7, 2}, '{256, 256, 4}, '{100, 200, 3}, '{511, 511, 15},
      '{0, 5, 8}, '{40, 0, 2}, '{255, 256, 1}, '{64, 64, 7}, '{256, 256, 0},
      '{200, 3, 9}
   };

   packed_pixel_frame_store dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_tone_in      (req_tone_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tone_out     (rsp_tone_out),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packed_pixel_frame_store verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) shadow.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            shadow.note_access(req_cmd, req_pixel_x, req_pixel_y, req_tone_in);
         if (rsp_valid === 1'b1 && !rsp_stall)
            shadow.check_response(rsp_tone_out, rsp_out_of_range);
      end
   end

   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_hold  <= $urandom_range(50, 300);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_hold % 16 < 6);
      endcase
   end

   task automatic send_word(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] tone);
      int gap;
      req_valid   <= 1'b1;
      valid_up     = 1'b1;
      req_cmd     <= cmd;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_tone_in <= tone;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 7);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_up   = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain_words();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up   = 1'b0;
      end
      while (shadow.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                               input logic [CFG_W-1:0] bpp);
      drain_words();
      csr_write <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= width;
      @(negedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= height;
      @(negedge clock);
      csr_index <= REG_BITS_PER_PIXEL;
      csr_wdata <= bpp;
      @(negedge clock);
      csr_write <= 1'b0;
      touched_x.delete();
      touched_y.delete();
   endtask

   task automatic send_random_word();
      int unsigned w, h, pick, slot;
      logic [7:0]  x, y;
      w    = shadow.span_x();
      h    = shadow.span_y();
      pick = $urandom_range(0, 99);
      if (pick < 10 || w == 0 || h == 0) begin
         send_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 45 && touched_x.size() > 0) begin
         // read back a written pixel or a neighbour in the same group of eight pixels
         slot = $urandom_range(0, touched_x.size() - 1);
         x    = touched_x[slot] ^ 8'($urandom_range(0, 7));
         send_word(CMD_READ, x, touched_y[slot], 8'($urandom));
      end else begin
         x = 8'($urandom_range(0, w - 1));
         y = 8'($urandom_range(0, h - 1));
         if (pick < 85) begin
            touched_x.push_back(x);
            touched_y.push_back(y);
            if (touched_x.size() > 16) begin
               void'(touched_x.pop_front());
               void'(touched_y.pop_front());
            end
            send_word(CMD_WRITE, x, y, 8'($urandom));
         end else begin
            send_word(CMD_READ, x, y, 8'($urandom));
         end
      end
   endtask

   initial begin
      shadow = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry, byte per pixel
      send_word(CMD_READ,  8'd0,   8'd0,   8'd0);
      send_word(CMD_WRITE, 8'd255, 8'd255, 8'd255);
      send_word(CMD_READ,  8'd255, 8'd255, 8'd0);
      send_word(CMD_WRITE, 8'd0,   8'd0,   8'hA5);
      send_word(CMD_READ,  8'd0,   8'd0,   8'hFF);
      send_word(CMD_READ,  8'd255, 8'd0,   8'd0);
      send_word(CMD_WRITE, 8'd128, 8'd127, 8'd1);
      send_word(CMD_READ,  8'd128, 8'd127, 8'd0);

      // width not a multiple of eight and illegal depth, plus edges of the image
      set_geometry(9'd20, 9'd2, 9'd3);
      send_word(CMD_WRITE, 8'd0,   8'd0,   8'hFF);
      send_word(CMD_WRITE, 8'd1,   8'd0,   8'h02);
      send_word(CMD_READ,  8'd0,   8'd0,   8'd0);
      send_word(CMD_READ,  8'd1,   8'd0,   8'd0);
      send_word(CMD_WRITE, 8'd23,  8'd1,   8'h01);
      send_word(CMD_READ,  8'd23,  8'd1,   8'd0);
      send_word(CMD_WRITE, 8'd24,  8'd0,   8'h03);
      send_word(CMD_READ,  8'd24,  8'd0,   8'd0);
      send_word(CMD_READ,  8'd0,   8'd2,   8'd0);
      send_word(CMD_WRITE, 8'd255, 8'd255, 8'hFF);
      send_word(CMD_READ,  8'd2,   8'd0,   8'd0);

      for (int p = 0; p < PHASES; p++) begin
         set_geometry(CFG_W'(phase_table[p][0]), CFG_W'(phase_table[p][1]),
                      CFG_W'(phase_table[p][2]));
         repeat (WORDS_PER_PHASE) send_random_word();
      end

      drain_words();
      repeat (10) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("packed_pixel_frame_store verification clean");
      end else begin
         $display("packed_pixel_frame_store verification failed");
      end
      $finish;
   end

endmodule

FILE: packed_pixel_frame_store.f
rtl/core/ppfs_pkg.sv
rtl/core/ppfs_ram.sv
rtl/core/packed_pixel_frame_store.sv
test/tb_top.sv
